[hdl/sha256_pkg.sv]
// SHA-256 hasher package: round constants, initial hash values, controller states
// and the command/status structs shared by controller and datapath. No dependencies.
`default_nettype none
package sha256_pkg;

    typedef logic [31:0] t_word;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word PAD_WORD = 32'h80000000;

    typedef enum logic [2:0] {
        ST_IDLE,     // waiting for a message word
        ST_PAD,      // pushing padding / length words
        ST_ROUND,    // running the 64 rounds
        ST_FOLD,     // add round variables into hash words
        ST_EMIT      // presenting digest words
    } t_state;

    // word source selection for a push into the window
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } t_src;

    typedef struct packed {
        logic       push;       // write a word into the window
        t_src       src;
        logic       len_hi;     // length word: high half when set
        logic       add_bytes;  // accumulate byte count from input
        logic       round_init; // load a..h from hash words
        logic       round_step; // one compression round
        logic       fold;       // hash += a..h
        logic       emit_next;  // advance digest index
        logic       finish;     // restore initial hash, clear count
    } t_cmd;

    typedef struct packed {
        logic [3:0] word_pos;
        logic       round_last;
        logic       emit_last;
    } t_status;

endpackage
`default_nettype wire

[hdl/sha256_message_hasher.sv]
// SHA-256 hasher top level: joins sha256_ctrl and sha256_datapath.
// Depends on sha256_pkg.
// Takes one 32-bit word per transfer when idle; every sixteenth word starts a
// compression of 64 rounds on the single round unit and then a fold, during which
// no words are taken. A final word is followed by one push per padding word, a
// second compression when the block holds 56 or more message bytes, and eight
// digest transfers, index 0 first, last flagged on index 7.
`default_nettype none
module sha256_message_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_message_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_digest_index,
    output logic             o_digest_last
);
    import sha256_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    sha256_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_valid_bytes, .i_end_of_message,
        .i_status (w_status), .o_cmd (w_cmd),
        .o_valid, .i_out_ready (i_ready)
    );

    sha256_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd (w_cmd),
        .i_message_word, .i_valid_bytes, .i_end_of_message,
        .o_status (w_status), .o_digest_word, .o_digest_index
    );

    assign o_digest_last = w_status.emit_last;

endmodule
`default_nettype wire

[hdl/sha256_datapath.sv]
// SHA-256 datapath: schedule window, round variables, hash words, byte counter
// and digest output index. Driven by sha256_ctrl through sha256_pkg structs.
`default_nettype none
module sha256_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sha256_pkg::t_cmd    i_cmd,
    input  wire logic [31:0]         i_message_word,
    input  wire logic [2:0]          i_valid_bytes,
    input  wire logic                i_end_of_message,
    output sha256_pkg::t_status      o_status,
    output logic [31:0]              o_digest_word,
    output logic [2:0]               o_digest_index
);
    import sha256_pkg::*;

    t_word      r_win [16];
    t_word      r_var [8];
    t_word      r_hash [8];
    logic [3:0] r_pos;
    logic [5:0] r_round;
    logic [60:0] r_bytes;
    logic [2:0] r_idx;

    logic [2:0]  w_vb;
    t_word       w_keep;
    t_word       w_in_word;
    t_word       w_push;
    logic [63:0] w_bits;
    logic [60:0] w_add;

    function automatic t_word rotr(t_word v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    always_comb begin
        w_vb = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
        case (w_vb)
            3'd0:    w_keep = 32'h00000000;
            3'd1:    w_keep = 32'hff000000;
            3'd2:    w_keep = 32'hffff0000;
            3'd3:    w_keep = 32'hffffff00;
            default: w_keep = 32'hffffffff;
        endcase
        // short final word carries its own 0x80 marker
        if (i_end_of_message && w_vb != 3'd4)
            w_in_word = (i_message_word & w_keep) | (PAD_WORD >> {w_vb, 3'b000});
        else
            w_in_word = i_message_word;
        w_add = i_end_of_message ? {58'd0, w_vb} : 61'd4;
        w_bits = {r_bytes, 3'b000};
        case (i_cmd.src)
            SRC_INPUT: w_push = w_in_word;
            SRC_PAD:   w_push = PAD_WORD;
            SRC_LEN:   w_push = i_cmd.len_hi ? w_bits[63:32] : w_bits[31:0];
            default:   w_push = '0;
        endcase
    end

    // schedule word for this round
    logic [3:0] w_r;
    t_word      w15, w2, w_sched, w_w;
    t_word      s0, s1, ch, mj, t1, t2;
    always_comb begin
        w_r = r_round[3:0];
        w15 = r_win[w_r + 4'd1];
        w2  = r_win[w_r + 4'd14];
        w_sched = r_win[w_r] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
                + r_win[w_r + 4'd9] + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
        w_w = (r_round >= 6'd16) ? w_sched : r_win[w_r];
        s1 = rotr(r_var[4], 6) ^ rotr(r_var[4], 11) ^ rotr(r_var[4], 25);
        ch = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
        t1 = r_var[7] + s1 + ch + ROUND_K[r_round] + w_w;
        s0 = rotr(r_var[0], 2) ^ rotr(r_var[0], 13) ^ rotr(r_var[0], 22);
        mj = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
        t2 = s0 + mj;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push)
            r_win[r_pos] <= w_push;
        else if (i_cmd.round_step)
            r_win[w_r] <= w_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= INIT_HASH[i];
                r_var[i]  <= '0;
            end
            r_pos   <= '0;
            r_round <= '0;
            r_bytes <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.push)
                r_pos <= r_pos + 4'd1;
            if (i_cmd.add_bytes)
                r_bytes <= r_bytes + w_add;
            if (i_cmd.round_init)
                for (int i = 0; i < 8; i++) r_var[i] <= r_hash[i];
            if (i_cmd.round_step) begin
                r_var[7] <= r_var[6];
                r_var[6] <= r_var[5];
                r_var[5] <= r_var[4];
                r_var[4] <= r_var[3] + t1;
                r_var[3] <= r_var[2];
                r_var[2] <= r_var[1];
                r_var[1] <= r_var[0];
                r_var[0] <= t1 + t2;
                r_round  <= r_round + 6'd1;
            end
            if (i_cmd.fold)
                for (int i = 0; i < 8; i++) r_hash[i] <= r_hash[i] + r_var[i];
            if (i_cmd.emit_next)
                r_idx <= r_idx + 3'd1;
            if (i_cmd.finish) begin
                for (int i = 0; i < 8; i++) r_hash[i] <= INIT_HASH[i];
                r_bytes <= '0;
                r_pos   <= '0;
            end
        end
    end

    assign o_status.word_pos   = r_pos;
    assign o_status.round_last = (r_round == 6'd63);
    assign o_status.emit_last  = (r_idx == 3'd7);
    assign o_digest_word       = r_hash[r_idx];
    assign o_digest_index      = r_idx;

`ifndef NO_ASSERTIONS
    a_round_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round_step && r_round == 6'd63 |=> r_round == 6'd0)
        else $error("round counter did not wrap");
    a_no_push_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && i_cmd.round_step))
        else $error("push during compression");
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_pos == 4'd0 && r_bytes == 61'd0)
        else $error("finish did not clear position");
`endif

endmodule
`default_nettype wire

[hdl/sha256_ctrl.sv]
// SHA-256 controller: sequences word pushes, padding, rounds and digest output.
// Uses sha256_pkg for states and command/status structs.
`default_nettype none
module sha256_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [2:0]          i_valid_bytes,
    input  wire logic                i_end_of_message,
    input  wire sha256_pkg::t_status i_status,
    output sha256_pkg::t_cmd         o_cmd,
    output logic                     o_valid,
    input  wire logic                i_out_ready
);
    import sha256_pkg::*;

    t_state r_state, n_state;
    logic   r_final, n_final;   // message has ended, emit after last block
    logic   r_pad80, n_pad80;   // 0x80 word still owed (full final word)
    logic   r_second, n_second; // marker sits at word 14 or 15, length goes in next block
    logic   r_len, n_len;       // current block carries the length words

    logic w_acc, w_full_last;
    assign w_acc = i_valid && o_ready;
    assign w_full_last = i_end_of_message && (i_valid_bytes >= 3'd4);

    always_comb begin
        n_state = r_state;
        n_final = r_final;
        n_pad80 = r_pad80;
        case (r_state)
            ST_IDLE: if (w_acc) begin
                n_final = i_end_of_message;
                n_pad80 = w_full_last;
                if (i_status.word_pos == 4'd15)
                    n_state = ST_ROUND;
                else if (i_end_of_message)
                    n_state = ST_PAD;
            end
            ST_PAD: begin
                n_pad80 = 1'b0;
                if (i_status.word_pos == 4'd15)
                    n_state = ST_ROUND;
            end
            ST_ROUND: if (i_status.round_last) n_state = ST_FOLD;
            ST_FOLD: begin
                if (!r_final)
                    n_state = ST_IDLE;
                else if (r_len)
                    n_state = ST_EMIT;
                else
                    n_state = ST_PAD;
            end
            ST_EMIT: if (i_out_ready && i_status.emit_last) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_cmd.src = SRC_ZERO;
        o_ready = (r_state == ST_IDLE);
        o_valid = (r_state == ST_EMIT);
        case (r_state)
            ST_IDLE: if (w_acc) begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_INPUT;
                o_cmd.add_bytes = 1'b1;
                o_cmd.round_init = (i_status.word_pos == 4'd15);
            end
            ST_PAD: begin
                o_cmd.push = 1'b1;
                // length goes in the last two words once the marker is placed
                if (r_pad80)
                    o_cmd.src = SRC_PAD;
                else if (r_second)
                    o_cmd.src = SRC_ZERO;
                else if (i_status.word_pos == 4'd14) begin
                    o_cmd.src = SRC_LEN;
                    o_cmd.len_hi = 1'b1;
                end else if (i_status.word_pos == 4'd15)
                    o_cmd.src = SRC_LEN;
                else
                    o_cmd.src = SRC_ZERO;
                o_cmd.round_init = (i_status.word_pos == 4'd15);
            end
            ST_ROUND: o_cmd.round_step = 1'b1;
            ST_FOLD:  o_cmd.fold = 1'b1;
            ST_EMIT: if (i_out_ready) begin
                o_cmd.emit_next = 1'b1;
                o_cmd.finish    = i_status.emit_last;
            end
            default: ;
        endcase
    end

    // marker pushed at 14 or 15 forces zeros + length into a second block
    always_comb begin
        n_second = r_second;
        n_len    = r_len;
        if (r_state == ST_IDLE && w_acc && i_end_of_message && !w_full_last
            && i_status.word_pos >= 4'd14)
            n_second = 1'b1;
        if (r_state == ST_PAD && r_pad80 && i_status.word_pos >= 4'd14)
            n_second = 1'b1;
        if (r_state == ST_PAD && !r_pad80 && !r_second && i_status.word_pos == 4'd15)
            n_len = 1'b1;
        if (r_state == ST_FOLD) begin
            n_second = 1'b0;
            n_len    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_final  <= 1'b0;
            r_pad80  <= 1'b0;
            r_second <= 1'b0;
            r_len    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_final  <= n_final;
            r_pad80  <= n_pad80;
            r_second <= n_second;
            r_len    <= n_len;
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("ready while emitting");
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == ST_IDLE)
        else $error("finish did not return to idle");
    a_round_after_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PAD && i_status.word_pos == 4'd15 |=> r_state == ST_ROUND)
        else $error("full block did not start rounds");
`endif

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Testbench for sha256_message_hasher: drives directed and random messages over the word
// channel and checks every digest transfer against a SHA-256 predictor.
// Depends on sha256_pkg (INIT_HASH, ROUND_K, PAD_WORD) and the hasher RTL.
`default_nettype none

class digest_scoreboard;
    logic [31:0] hash_st [8];
    logic [31:0] block_buf [16];
    int unsigned word_pos;
    logic [60:0] byte_count;
    logic [31:0] digest_q [$];
    logic [2:0]  index_q [$];
    int unsigned errors;

    function new();
        reset_state();
        errors = 0;
    endfunction

    function void reset_state();
        for (int i = 0; i < 8; i++) hash_st[i] = sha256_pkg::INIT_HASH[i];
        word_pos = 0;
        byte_count = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function void compress();
        logic [31:0] v [8];
        logic [31:0] w [64];
        logic [31:0] t1, t2;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) w[r] = block_buf[r];
            else w[r] = w[r-16] + w[r-7]
                + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
                + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = hash_st[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_st[i] += v[i];
    endfunction

    function void push_word(logic [31:0] w);
        block_buf[word_pos] = w;
        word_pos = (word_pos + 1) % 16;
        if (word_pos == 0) compress();
    endfunction

    // note one accepted input transfer
    function void note_word(logic [31:0] word, logic [2:0] vb, logic eom);
        logic [31:0] keep;
        logic [63:0] bits;
        int unsigned n;
        n = (vb > 4) ? 4 : vb;
        if (!eom) begin
            push_word(word);
            byte_count += 4;
            return;
        end
        byte_count += n;
        if (n == 4) begin
            push_word(word);
            push_word(sha256_pkg::PAD_WORD);
        end else begin
            keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
            push_word((word & keep) | (sha256_pkg::PAD_WORD >> (8 * n)));
        end
        while (word_pos != 14) push_word(32'h0);
        bits = {byte_count, 3'b000};
        push_word(bits[63:32]);
        push_word(bits[31:0]);
        for (int i = 0; i < 8; i++) begin
            digest_q.push_back(hash_st[i]);
            index_q.push_back(i[2:0]);
        end
        reset_state();
    endfunction

    function void check_digest(logic [31:0] word, logic [2:0] idx, logic last);
        logic [31:0] ew;
        logic [2:0]  ei;
        if (digest_q.size() == 0) begin
            $display("%0t: unexpected digest transfer word=%h idx=%0d", $time, word, idx);
            errors++;
            return;
        end
        ew = digest_q.pop_front();
        ei = index_q.pop_front();
        if (word !== ew) begin
            $display("%0t: digest_word exp %h got %h", $time, ew, word);
            errors++;
        end
        if (idx !== ei) begin
            $display("%0t: digest_index exp %0d got %0d", $time, ei, idx);
            errors++;
        end
        if (last !== (ei == 7)) begin
            $display("%0t: digest_last exp %0d got %0d", $time, ei == 7, last);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [31:0] msg_word = '0;
    logic [2:0]  msg_vb = '0;
    logic        msg_eom = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [31:0] dig_word;
    logic [2:0]  dig_idx;
    logic        dig_last;
    logic        long_hold = 0;
    bit          drive_done = 0;
    int unsigned items_sent = 0;
    int unsigned hold_left = 0;
    bit          hold_taken = 0;

    digest_scoreboard sb = new();

    sha256_message_hasher u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_message_word(msg_word), .i_valid_bytes(msg_vb),
        .i_end_of_message(msg_eom),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_digest_word(dig_word), .o_digest_index(dig_idx),
        .o_digest_last(dig_last)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // sample both channels at the edge, before the drivers' updates land
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) sb.note_word(msg_word, msg_vb, msg_eom);
        if (rst_n && out_valid && out_ready) sb.check_digest(dig_word, dig_idx, dig_last);
    end

    // receiver stall pattern, with one long hold-off when requested
    always @(posedge clk) begin
        if (long_hold && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 600;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else case (($time / 800) % 3)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    int unsigned gap_left = 0;
    int unsigned burst_left = 0;

    // present one item; returns after its transfer
    task automatic send_word(logic [31:0] w, logic [2:0] vb, logic eom);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                repeat (gap_left) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        msg_word <= w;
        msg_vb <= vb;
        msg_eom <= eom;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.digest_q.size() != 0) @(posedge clk);
    endtask

    task automatic send_message(int unsigned nwords, logic [2:0] last_vb);
        for (int i = 0; i < nwords; i++)
            send_word($urandom(), ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                      1'b0);
        send_word($urandom(), last_vb, 1'b1);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty message, each short ending, extreme fields
        send_word(32'hffffffff, 3'd0, 1'b1);
        send_word(32'h00000000, 3'd4, 1'b1);
        send_word(32'hffffffff, 3'd1, 1'b1);
        send_word(32'hffffffff, 3'd2, 1'b1);
        send_word(32'hffffffff, 3'd3, 1'b1);
        send_word(32'ha5a5a5a5, 3'd7, 1'b1);
        send_word(32'h12345678, 3'd5, 1'b0);
        send_word(32'h9abcdef0, 3'd2, 1'b0);
        send_word(32'hdeadbeef, 3'd6, 1'b1);
        // 13 full words + 4-byte end: padding spills into a second block
        send_message(13, 3'd4);
        wait_drained();
        // long receiver hold while the sender keeps offering
        long_hold <= 1'b1;
        send_message(2, 3'd3);
        send_message(3, 3'd1);
        send_message(1, 3'd4);
        wait_drained();
        // random messages, mostly short, a few spanning blocks
        while (items_sent < 100) begin
            send_message(($urandom_range(0, 5) == 0) ? $urandom_range(14, 34)
                         : $urandom_range(0, 8), 3'($urandom_range(0, 7)));
            if ($urandom_range(0, 4) == 0) wait_drained();
        end
        wait_drained();
        repeat (200) @(posedge clk);
        drive_done = 1;
    end

    initial begin
        wait (drive_done);
        if (sb.errors == 0 && sb.digest_q.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
hdl/sha256_pkg.sv
hdl/sha256_datapath.sv
hdl/sha256_ctrl.sv
hdl/sha256_message_hasher.sv
bench/tb_top.sv
